FILE: rtl/vec3_arithmetic_unit_assert.svh
// Assertion macros for the vec3 arithmetic unit checker.
`ifndef VEC3_ARITHMETIC_UNIT_ASSERT_SVH
`define VEC3_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vec3 unit port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vec3 unit port check failed");

`endif

FILE: rtl/vau_pkg.sv
package vau_pkg;

    // operation kinds
    localparam logic [2:0] KIND_ADD   = 3'd0;
    localparam logic [2:0] KIND_SUB   = 3'd1;
    localparam logic [2:0] KIND_CROSS = 3'd2;
    localparam logic [2:0] KIND_SCALE = 3'd3;
    localparam logic [2:0] KIND_DIV   = 3'd4;
    localparam logic [2:0] KIND_DOT   = 3'd5;
    localparam logic [2:0] KIND_LEN   = 3'd6;
    localparam logic [2:0] KIND_NORM  = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_NORM_ZERO = 2'd2;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // one root bit per stage of the square root pipe
    localparam int SQRT_STAGES = 32;

    // sideband carried along the root and divide pipes
    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0]       neg;     // per-lane sign of the final quotient
        logic [2:0][31:0] mag;     // |a| per lane
        logic [31:0]      den;     // |b_x|
        logic             bneg;
        logic [2:0][31:0] r;       // vector result for the non-divide kinds
        logic [31:0]      sc;
        logic [1:0]       status;
        logic             sat;
    } t_side;

endpackage

FILE: rtl/vec3_arithmetic_unit.sv
// Every operation kind takes the same path through the same stages, from input accept to o_valid.
// Throughput: one item per cycle; the whole pipe advances together and holds on a stall.
// Depth is set by the 32-stage square root pipe and the (32 + FRAC_BITS)-stage divider.
// Reset: synchronous, active low; clears all valid bits, payload registers are not reset.
module vec3_arithmetic_unit import vau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_scalar_result,
    output logic [1:0]         o_status,
    output logic               o_saturated
);

    // quotient width: |a| << FRAC_BITS plus rounding half fits in 32 + FRAC_BITS bits
    localparam int QW = 32 + FRAC_BITS;
    localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    // front-end sideband, carried through the multiply and sum stages
    typedef struct packed {
        logic [2:0]       kind;
        logic [2:0][31:0] sum;     // add/sub result, already clamped
        logic             sum_sat;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [31:0]      den;
        logic             bneg;
        logic             bzero;
    } t_front;

    // {saturated, value} for a 66-bit signed value clamped to 32 bits
    function automatic logic [32:0] f_clamp(input logic signed [65:0] v);
        logic [32:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, Q_MAX};
        end else if (v < SAT_LO) begin
            res = {1'b1, Q_MIN};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // global advance: the output register is free or being drained
    logic en;
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: operand steering for the six multipliers, add/sub, magnitudes
    // ------------------------------------------------------------------
    logic signed [31:0] a_in [3];
    logic signed [31:0] b_in [3];
    assign a_in[0] = i_a_x;
    assign a_in[1] = i_a_y;
    assign a_in[2] = i_a_z;
    assign b_in[0] = i_b_x;
    assign b_in[1] = i_b_y;
    assign b_in[2] = i_b_z;

    logic signed [31:0] n1_ma [6];
    logic signed [31:0] n1_mb [6];
    t_front             n1_front;
    logic signed [31:0] r1_ma [6];
    logic signed [31:0] r1_mb [6];
    t_front             r1_front;
    logic               r1_valid;

    always_comb begin
        logic signed [32:0] s33;
        n1_front.kind    = i_kind;
        n1_front.sum_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i_kind == KIND_SUB) begin
                s33 = 33'(a_in[i]) - 33'(b_in[i]);
            end else begin
                s33 = 33'(a_in[i]) + 33'(b_in[i]);
            end
            if (s33[32] != s33[31]) begin
                n1_front.sum[i]  = s33[32] ? Q_MIN : Q_MAX;
                n1_front.sum_sat = 1'b1;
            end else begin
                n1_front.sum[i] = s33[31:0];
            end
            n1_front.neg[i] = a_in[i][31];
            n1_front.mag[i] = a_in[i][31] ? (~a_in[i] + 32'd1) : a_in[i];
        end
        n1_front.bneg  = i_b_x[31];
        n1_front.den   = i_b_x[31] ? (~i_b_x + 32'd1) : i_b_x;
        n1_front.bzero = (i_b_x == 32'sd0);

        // products pair up: cross uses all six as (even - odd),
        // the other kinds use only the even slots
        for (int j = 0; j < 6; j++) begin
            n1_ma[j] = '0;
            n1_mb[j] = '0;
        end
        case (i_kind)
            KIND_CROSS: begin
                n1_ma[0] = a_in[1]; n1_mb[0] = b_in[2];
                n1_ma[1] = a_in[2]; n1_mb[1] = b_in[1];
                n1_ma[2] = a_in[2]; n1_mb[2] = b_in[0];
                n1_ma[3] = a_in[0]; n1_mb[3] = b_in[2];
                n1_ma[4] = a_in[0]; n1_mb[4] = b_in[1];
                n1_ma[5] = a_in[1]; n1_mb[5] = b_in[0];
            end
            KIND_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[2*i] = a_in[i];
                    n1_mb[2*i] = b_in[0];
                end
            end
            KIND_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[2*i] = a_in[i];
                    n1_mb[2*i] = b_in[i];
                end
            end
            KIND_LEN, KIND_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    n1_ma[2*i] = a_in[i];
                    n1_mb[2*i] = a_in[i];
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: products (exact, 64 bits)
    // ------------------------------------------------------------------
    logic signed [63:0] r2_p [6];
    t_front             r2_front;
    logic               r2_valid;

    // ------------------------------------------------------------------
    // Stage 3: pair differences and three-term sum (66 bits)
    // ------------------------------------------------------------------
    logic signed [65:0] r3_v [3];
    logic signed [65:0] r3_dot;
    t_front             r3_front;
    logic               r3_valid;

    // ------------------------------------------------------------------
    // Stage 4: round half up, clamp, build the sideband
    // ------------------------------------------------------------------
    t_side       n4_side;
    t_side       r4_side;
    logic [63:0] r4_s;
    logic        r4_valid;

    always_comb begin
        logic [32:0] rc [3];
        logic [32:0] rd;
        for (int i = 0; i < 3; i++) begin
            rc[i] = f_clamp((r3_v[i] + HALF) >>> FRAC_BITS);
        end
        rd = f_clamp((r3_dot + HALF) >>> FRAC_BITS);

        n4_side.kind   = r3_front.kind;
        n4_side.neg    = r3_front.neg;
        n4_side.mag    = r3_front.mag;
        n4_side.den    = r3_front.den;
        n4_side.bneg   = r3_front.bneg;
        n4_side.r      = '0;
        n4_side.sc     = '0;
        n4_side.status = ST_OK;
        n4_side.sat    = 1'b0;
        case (r3_front.kind)
            KIND_ADD, KIND_SUB: begin
                n4_side.r   = r3_front.sum;
                n4_side.sat = r3_front.sum_sat;
            end
            KIND_CROSS, KIND_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n4_side.r[i] = rc[i][31:0];
                end
                n4_side.sat = rc[0][32] | rc[1][32] | rc[2][32];
            end
            KIND_DOT: begin
                n4_side.sc  = rd[31:0];
                n4_side.sat = rd[32];
            end
            KIND_DIV: begin
                if (r3_front.bzero) begin
                    n4_side.status = ST_DIV_ZERO;
                end
            end
            KIND_NORM: begin
                if (r3_dot == 66'sd0) begin
                    n4_side.status = ST_NORM_ZERO;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 6; j++) begin
                r1_ma[j] <= n1_ma[j];
                r1_mb[j] <= n1_mb[j];
                r2_p[j]  <= r1_ma[j] * r1_mb[j];
            end
            r1_front <= n1_front;
            r2_front <= r1_front;
            for (int i = 0; i < 3; i++) begin
                r3_v[i] <= 66'(r2_p[2*i]) - 66'(r2_p[2*i+1]);
            end
            r3_dot   <= 66'(r2_p[0]) + 66'(r2_p[2]) + 66'(r2_p[4]);
            r3_front <= r2_front;
            r4_side  <= n4_side;
            // sum of squares is below 2^64 for length and normalize
            r4_s     <= r3_dot[63:0];
        end
    end

    // ------------------------------------------------------------------
    // Square root pipe (33 stages including the rounding step)
    // ------------------------------------------------------------------
    logic        sq_valid;
    logic [31:0] sq_len;
    t_side       sq_side;

    vau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_s     (r4_s),
        .i_side  (r4_side),
        .o_valid (sq_valid),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: pick divisor, form rounded numerators, finish length
    // ------------------------------------------------------------------
    logic [31:0]   n5_den;
    logic [QW-1:0] n5_num [3];
    t_side         n5_side;
    logic [31:0]   r5_den;
    logic [QW-1:0] r5_num [3];
    t_side         r5_side;
    logic          r5_valid;

    always_comb begin
        n5_den  = (sq_side.kind == KIND_DIV) ? sq_side.den : sq_len;
        for (int i = 0; i < 3; i++) begin
            // (|a| << FRAC_BITS) + den/2: rounds the quotient magnitude half away from zero
            n5_num[i] = {sq_side.mag[i], {FRAC_BITS{1'b0}}} + QW'(n5_den[31:1]);
        end
        n5_side = sq_side;
        if (sq_side.kind == KIND_LEN) begin
            if (sq_len > Q_MAX) begin
                n5_side.sc  = Q_MAX;
                n5_side.sat = 1'b1;
            end else begin
                n5_side.sc = sq_len;
            end
        end
        if (sq_side.kind == KIND_DIV) begin
            n5_side.neg = sq_side.neg ^ {3{sq_side.bneg}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_den  <= n5_den;
            r5_side <= n5_side;
            for (int i = 0; i < 3; i++) begin
                r5_num[i] <= n5_num[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider pipe, three lanes, one quotient bit per stage
    // ------------------------------------------------------------------
    logic          dv_valid;
    logic [QW-1:0] dv_quo [3];
    t_side         dv_side;

    vau_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_valid),
        .i_den   (r5_den),
        .i_num   (r5_num),
        .i_side  (r5_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // ------------------------------------------------------------------
    // Output stage: sign and clamp quotients, select per kind
    // ------------------------------------------------------------------
    logic [31:0] n_out_r [3];
    logic [31:0] n_out_sc;
    logic [1:0]  n_out_status;
    logic        n_out_sat;
    logic [31:0] r_out_r [3];
    logic [31:0] r_out_sc;
    logic [1:0]  r_out_status;
    logic        r_out_sat;

    always_comb begin
        logic [31:0] qv [3];
        logic        qs [3];
        for (int i = 0; i < 3; i++) begin
            if (dv_side.neg[i]) begin
                // a magnitude of exactly 2^31 still fits as the minimum value
                qs[i] = (|dv_quo[i][QW-1:32]) | (dv_quo[i][31] & (|dv_quo[i][30:0]));
                qv[i] = qs[i] ? Q_MIN : (~dv_quo[i][31:0]) + 32'd1;
            end else begin
                qs[i] = |dv_quo[i][QW-1:31];
                qv[i] = qs[i] ? Q_MAX : dv_quo[i][31:0];
            end
        end
        n_out_status = dv_side.status;
        if ((dv_side.kind inside {KIND_DIV, KIND_NORM}) && dv_side.status == ST_OK) begin
            for (int i = 0; i < 3; i++) begin
                n_out_r[i] = qv[i];
            end
            n_out_sc  = '0;
            n_out_sat = qs[0] | qs[1] | qs[2];
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_out_r[i] = dv_side.r[i];
            end
            n_out_sc  = dv_side.sc;
            n_out_sat = dv_side.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_out_r[i] <= n_out_r[i];
            end
            r_out_sc     <= n_out_sc;
            r_out_status <= n_out_status;
            r_out_sat    <= n_out_sat;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= sq_valid;
            r_out_valid <= dv_valid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_r_x           = r_out_r[0];
    assign o_r_y           = r_out_r[1];
    assign o_r_z           = r_out_r[2];
    assign o_scalar_result = r_out_sc;
    assign o_status        = r_out_status;
    assign o_saturated     = r_out_sat;

endmodule

FILE: rtl/vau_sqrt.sv
module vau_sqrt import vau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_s,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_len,
    output t_side       o_side
);

    logic [63:0] r_rem  [SQRT_STAGES];
    logic [63:0] r_res  [SQRT_STAGES];
    t_side       r_side [SQRT_STAGES];
    logic        r_v    [SQRT_STAGES];
    logic [63:0] n_rem  [SQRT_STAGES];
    logic [63:0] n_res  [SQRT_STAGES];
    logic [31:0] r_len;
    t_side       r_len_side;
    logic        r_len_v;

    // one restoring step per stage, bit weight 4^(31-k)
    always_comb begin
        logic [63:0] rem_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic [63:0] bitw;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                rem_in = i_s;
                res_in = '0;
            end else begin
                rem_in = r_rem[k-1];
                res_in = r_res[k-1];
            end
            bitw  = 64'd1 << (62 - 2 * k);
            trial = res_in + bitw;
            if (rem_in >= trial) begin
                n_rem[k] = rem_in - trial;
                n_res[k] = (res_in >> 1) + bitw;
            end else begin
                n_rem[k] = rem_in;
                n_res[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
            // round to nearest: bump when the remainder exceeds the root
            r_len      <= r_res[SQRT_STAGES-1][31:0]
                          + 32'(r_rem[SQRT_STAGES-1] > r_res[SQRT_STAGES-1]);
            r_len_side <= r_side[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
            r_len_v <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
            r_len_v <= r_v[SQRT_STAGES-1];
        end
    end

    assign o_valid = r_len_v;
    assign o_len   = r_len;
    assign o_side  = r_len_side;

endmodule

FILE: rtl/vau_div.sv
module vau_div import vau_pkg::*; #(
    parameter int QW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_den,
    input  logic [QW-1:0] i_num [3],
    input  t_side         i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo [3],
    output t_side         o_side
);

    logic [QW-1:0] r_sh   [QW][3];
    logic [31:0]   r_rem  [QW][3];
    logic [31:0]   r_den  [QW];
    t_side         r_side [QW];
    logic          r_v    [QW];
    logic [QW-1:0] n_sh   [QW][3];
    logic [31:0]   n_rem  [QW][3];

    // one quotient bit per stage; numerator bits shift out the top,
    // quotient bits shift in at the bottom
    always_comb begin
        logic [QW-1:0] sh_in;
        logic [31:0]   rem_in;
        logic [31:0]   den_in;
        logic [32:0]   t;
        logic [32:0]   d;
        logic          ge;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    sh_in  = i_num[l];
                    rem_in = '0;
                    den_in = i_den;
                end else begin
                    sh_in  = r_sh[k-1][l];
                    rem_in = r_rem[k-1][l];
                    den_in = r_den[k-1];
                end
                t  = {rem_in, sh_in[QW-1]};
                d  = t - {1'b0, den_in};
                ge = (t >= {1'b0, den_in});
                n_rem[k][l] = ge ? d[31:0] : t[31:0];
                n_sh[k][l]  = {sh_in[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_sh[k][l]  <= n_sh[k][l];
                    r_rem[k][l] <= n_rem[k][l];
                end
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quo[0] = r_sh[QW-1][0];
    assign o_quo[1] = r_sh[QW-1][1];
    assign o_quo[2] = r_sh[QW-1][2];

endmodule

FILE: rtl/vau_checker.sv
module vau_checker import vau_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [2:0]         i_kind,
    input logic signed [31:0] i_a_x,
    input logic signed [31:0] i_a_y,
    input logic signed [31:0] i_a_z,
    input logic signed [31:0] i_b_x,
    input logic signed [31:0] i_b_y,
    input logic signed [31:0] i_b_z,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_r_x,
    input logic signed [31:0] o_r_y,
    input logic signed [31:0] o_r_z,
    input logic signed [31:0] o_scalar_result,
    input logic [1:0]         o_status,
    input logic               o_saturated
);

`include "vec3_arithmetic_unit_assert.svh"

    // a stalled result holds
    `VAU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_r_x) && $stable(o_r_y) && $stable(o_r_z) && $stable(o_scalar_result) && $stable(o_status) && $stable(o_saturated))

    // input side stalls only behind a blocked result
    `VAU_ASSERT_IMP(a_stall_src, i_clk, i_rst_n, 1'b1, o_stall == (o_valid && i_stall))

    // an error result is all zero and never flagged saturated
    `VAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_r_x == 0 && o_r_y == 0 && o_r_z == 0 && o_scalar_result == 0 && !o_saturated)

    // vector and scalar results never both nonzero
    `VAU_ASSERT_IMP(a_vec_or_scalar, i_clk, i_rst_n, o_valid && (o_r_x != 0 || o_r_y != 0 || o_r_z != 0), o_scalar_result == 0)

endmodule

bind vec3_arithmetic_unit vau_checker u_checker (.*);
